/* design/sfrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_pkg
// shared types and constants of the sync framed receiver with checksum
// ----------------------------------------------------------------------------
package sfrc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // payload byte positions that trigger back-end steps
    localparam logic [POS_W-1:0] POS_SUM01 = 4'd8;   // words 0 and 1 complete
    localparam logic [POS_W-1:0] POS_SUM2  = 4'd12;  // word 2 complete
    localparam logic [POS_W-1:0] POS_LAST  = 4'd15;  // last checksum byte

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hFF;

    // payload byte handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
    } t_item;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

/* design/sfrc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_front
// accepts bytes, hunts for the sync run and tags payload bytes with position
// ----------------------------------------------------------------------------
module sfrc_front #(
    parameter int unsigned SYNC_BYTES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_valid,
    input  logic [7:0]          i_rx_byte,
    output logic                o_stall,
    input  sfrc_pkg::t_q_status i_q_status,
    output logic                o_push,
    output sfrc_pkg::t_item     o_item
);
    import sfrc_pkg::*;

    localparam int unsigned SYNC_W = $clog2(SYNC_BYTES + 1);
    localparam logic [SYNC_W-1:0] SYNC_LAST = SYNC_W'(SYNC_BYTES - 1);

    logic [BYTE_W-1:0] r_sync_value;
    logic [SYNC_W-1:0] r_sync_cnt, n_sync_cnt;
    logic              r_in_payload, n_in_payload;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              accept;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;
    assign o_push  = accept && r_in_payload;
    assign o_item  = '{data: i_rx_byte, pos: r_pos};

    always_comb begin
        n_sync_cnt   = r_sync_cnt;
        n_in_payload = r_in_payload;
        n_pos        = r_pos;
        if (accept) begin
            if (r_in_payload) begin
                n_pos = r_pos + 1'b1;
                if (r_pos == POS_LAST) begin
                    n_in_payload = 1'b0;
                end
            end else if (i_rx_byte != r_sync_value) begin
                // wrong byte drops the run, it does not start a new one
                n_sync_cnt = '0;
            end else if (r_sync_cnt == SYNC_LAST) begin
                n_sync_cnt   = '0;
                n_in_payload = 1'b1;
                n_pos        = '0;
            end else begin
                n_sync_cnt = r_sync_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= SYNC_RESET;
            r_sync_cnt   <= '0;
            r_in_payload <= 1'b0;
            r_pos        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_sync_value <= i_cfg_data;
            end
            r_sync_cnt   <= n_sync_cnt;
            r_in_payload <= n_in_payload;
            r_pos        <= n_pos;
        end
    end

endmodule

/* design/sfrc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
module sfrc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfrc_pkg::t_item     i_item,
    input  logic                i_pop,
    output sfrc_pkg::t_item     o_item,
    output sfrc_pkg::t_q_status o_status
);
    import sfrc_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_item         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full || i_pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

/* design/sfrc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfrc_back
// assembles payload words, checks the additive checksum, holds the result
// ----------------------------------------------------------------------------
module sfrc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sfrc_pkg::t_q_status i_q_status,
    input  sfrc_pkg::t_item     i_item,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [31:0]         o_command_word,
    output logic [31:0]         o_param_float_bits,
    output logic signed [31:0]  o_param_integer
);
    import sfrc_pkg::*;

    logic [WORD_W-1:0]        r_w0, r_w1, r_w2;
    logic [WORD_W-BYTE_W-1:0] r_w3_lo;
    logic [WORD_W-1:0]        r_sum;
    logic                     r_out_valid, n_out_valid;
    logic [WORD_W-1:0]        r_out_cmd, r_out_flt, r_out_int;
    logic                     is_last;
    logic                     match;
    logic                     load_out;
    logic [1:0]               word_sel;
    logic [1:0]               lane;

    // results move on only when the output register can take one
    assign o_pop    = !i_q_status.empty && !(r_out_valid && i_out_stall);
    assign word_sel = i_item.pos[3:2];
    assign lane     = i_item.pos[1:0];
    assign is_last  = (i_item.pos == POS_LAST);
    assign match    = (r_sum == {i_item.data, r_w3_lo});
    assign load_out = o_pop && is_last && match;

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            unique case (word_sel)
                2'd0: r_w0[{lane, 3'b000} +: BYTE_W] <= i_item.data;
                2'd1: r_w1[{lane, 3'b000} +: BYTE_W] <= i_item.data;
                2'd2: r_w2[{lane, 3'b000} +: BYTE_W] <= i_item.data;
                default: begin
                    if (lane != 2'd3) begin
                        r_w3_lo[{lane, 3'b000} +: BYTE_W] <= i_item.data;
                    end
                end
            endcase
            // partial sums once each word is complete
            if (i_item.pos == POS_SUM01) begin
                r_sum <= r_w0 + r_w1;
            end else if (i_item.pos == POS_SUM2) begin
                r_sum <= r_sum + r_w2;
            end
        end
        if (load_out) begin
            r_out_cmd <= r_w0;
            r_out_flt <= r_w1;
            r_out_int <= r_w2;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_command_word     = r_out_cmd;
    assign o_param_float_bits = r_out_flt;
    assign o_param_integer    = signed'(r_out_int);

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_pop && is_last && match))
        else $error("result without a checked frame");
    a_hold_blocks_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_pop)
        else $error("queue popped while result held");
    a_bad_frame_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && is_last && !match) |=> !r_out_valid)
        else $error("failing frame produced a result");
`endif

endmodule

/* design/sync_frame_receiver_checksum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_receiver_checksum
// sync framed packet receiver with a 32-bit additive checksum
// ----------------------------------------------------------------------------
// Takes one received byte per word on the input channel. Bytes are dropped
// until SYNC_BYTES consecutive bytes equal the sync value register (reset
// 0xFF); a mismatching byte restarts the hunt. The next sixteen bytes are
// payload, little-endian, forming command, float bits, integer parameter and
// checksum words. If the wrapping sum of the first three equals the checksum,
// one result word carries the three values out; otherwise the frame is
// dropped silently. Either way the block goes back to hunting for sync.
// It takes one byte per clock unless a held result backs up the queue: the
// front end classifies each byte as it is accepted and the back end consumes
// one queued byte per cycle. The last byte of a frame is written into the
// queue when accepted, and the checksum compare then loads the result into
// the output register. The output register lets the front keep accepting
// while a result waits; only a held result plus a full two-entry queue
// stalls the input. No clearing pass after reset. The sync value register is
// written whenever the config channel is valid.
// ----------------------------------------------------------------------------
module sync_frame_receiver_checksum #(
    parameter int unsigned SYNC_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config channel, sync value register
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data,
    // input byte channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [31:0]        o_command_word,
    output logic [31:0]        o_param_float_bits,
    output logic signed [31:0] o_param_integer
);
    import sfrc_pkg::*;

    t_q_status q_status;
    t_item     push_item;
    t_item     head_item;
    logic      push;
    logic      pop;

    // register write never waits
    assign o_cfg_ready = 1'b1;

    // front: sync hunt and payload position tagging
    sfrc_front #(
        .SYNC_BYTES (SYNC_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .o_stall    (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    // decouples byte intake from word assembly and output back-pressure
    sfrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_status(q_status)
    );

    // back: word assembly, running checksum, output register
    sfrc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_status        (q_status),
        .i_item            (head_item),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_command_word    (o_command_word),
        .o_param_float_bits(o_param_float_bits),
        .o_param_integer   (o_param_integer)
    );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sync framed receiver with additive checksum
// ----------------------------------------------------------------------------
// Feeds received bytes through the input channel from a queue that the
// stimulus process fills, phase by phase. A model of the frame hunt and the
// checksum runs on every accepted byte and queues the frames that should come
// out; the result side pops and compares them field by field. The sync value
// register is rewritten between phases once the block has gone quiet. One
// phase holds the result side off long enough to back the block up into its
// input. Idling on both sides changes every second phase.
// ----------------------------------------------------------------------------
module tb;

    import sfrc_pkg::*;

    localparam int unsigned SYNC_RUN      = 8;     // sync bytes in front of each frame
    localparam int unsigned PAYLOAD_LEN   = 16;
    localparam int unsigned PHASES        = 6;
    localparam int unsigned PHASE_BYTES   = 320;   // stimulus bytes per random phase
    localparam int unsigned HOLD_LEN      = 400;   // long result-side hold, in cycles
    localparam int unsigned TAIL_CYCLES   = 8;     // quiet cycles after the last result
    localparam int unsigned DRAIN_LIMIT   = 20000;

    // kinds of stimulus units in the random part
    typedef enum logic [1:0] {
        UNIT_GOOD,
        UNIT_BAD_SUM,
        UNIT_BROKEN_SYNC,
        UNIT_NOISE
    } t_unit_kind;

    typedef struct {
        logic [WORD_W-1:0]        cmd_word;
        logic [WORD_W-1:0]        flt_bits;
        logic signed [WORD_W-1:0] int_param;
    } t_frame;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [BYTE_W-1:0]        i_cfg_data  = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic [BYTE_W-1:0]        i_rx_byte   = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic [WORD_W-1:0]        o_command_word;
    logic [WORD_W-1:0]        o_param_float_bits;
    logic signed [WORD_W-1:0] o_param_integer;

    // stimulus side
    logic [BYTE_W-1:0] bytes_pending[$];
    int unsigned       bytes_pushed   = 0;
    int unsigned       bytes_taken    = 0;
    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_idle_pct  = 0;

    // long hold of the result side
    logic              hold_armed     = 1'b0;
    int unsigned       hold_cycles    = 0;

    // frame model: sync value, byte position and assembled words
    logic [BYTE_W-1:0] sync_now       = SYNC_RESET;
    int unsigned       frame_pos      = 0;
    logic [WORD_W-1:0] payload[4]     = '{default: '0};
    t_frame            frames_due[$];

    int unsigned       fail_count     = 0;

    sync_frame_receiver_checksum #(
        .SYNC_BYTES(SYNC_RUN)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_command_word    (o_command_word),
        .o_param_float_bits(o_param_float_bits),
        .o_param_integer   (o_param_integer)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // frame model, run once per accepted byte
    // ------------------------------------------------------------------------
    function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
        int unsigned       pos;
        logic [WORD_W-1:0] sum;
        t_frame            f;
        // hunting for sync: a wrong byte restarts the run and is not kept
        if (frame_pos < SYNC_RUN) begin
            if (b != sync_now)
                frame_pos = 0;
            else
                frame_pos++;
            return;
        end
        // payload bytes are plain data, even when they equal the sync value
        pos = frame_pos - SYNC_RUN;
        payload[pos / 4][(pos % 4) * 8 +: 8] = b;
        frame_pos++;
        if (frame_pos == SYNC_RUN + PAYLOAD_LEN) begin
            frame_pos = 0;
            sum = payload[0] + payload[1] + payload[2];
            // bad checksum: the frame vanishes without a result
            if (sum == payload[3]) begin
                f.cmd_word  = payload[0];
                f.flt_bits  = payload[1];
                f.int_param = payload[2];
                frames_due.push_back(f);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // input driver: one byte word per accepted handshake
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                absorb_byte(i_rx_byte);
                bytes_taken++;
            end
            // a stalled word stays put; otherwise offer the next one or idle
            if (i_in_valid && o_in_stall) begin
                i_in_valid <= 1'b1;
            end else if (bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_rx_byte  <= bytes_pending.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // long hold counter, runs once when armed
    always @(posedge i_clk) begin
        if (hold_armed && hold_cycles < HOLD_LEN)
            hold_cycles <= hold_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // result monitor: compare each accepted word with the oldest frame due
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : p_collect
        t_frame want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (frames_due.size() == 0) begin
                    $error("result word with no frame due: cmd %h", o_command_word);
                    fail_count++;
                end else begin
                    want = frames_due.pop_front();
                    if (o_command_word !== want.cmd_word) begin
                        $error("command_word: expected %h, got %h",
                               want.cmd_word, o_command_word);
                        fail_count++;
                    end
                    if (o_param_float_bits !== want.flt_bits) begin
                        $error("param_float_bits: expected %h, got %h",
                               want.flt_bits, o_param_float_bits);
                        fail_count++;
                    end
                    if (o_param_integer !== want.int_param) begin
                        $error("param_integer: expected %0d, got %0d",
                               want.int_param, o_param_integer);
                        fail_count++;
                    end
                end
            end
            i_out_stall <= (hold_armed && hold_cycles < HOLD_LEN)
                           || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        bytes_pending.push_back(b);
        bytes_pushed++;
    endtask

    task automatic queue_frame(input logic [WORD_W-1:0] c, input logic [WORD_W-1:0] fb,
                               input logic [WORD_W-1:0] ip, input logic [WORD_W-1:0] chk);
        logic [WORD_W-1:0] w[4];
        w = '{c, fb, ip, chk};
        repeat (SYNC_RUN) queue_byte(sync_now);
        for (int i = 0; i < PAYLOAD_LEN; i++)
            queue_byte(w[i / 4][(i % 4) * 8 +: 8]);
    endtask

    // payload word with a bias toward the edges and sync look-alikes
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return {4{sync_now}};
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_unit(input t_unit_kind kind);
        logic [WORD_W-1:0] c, fb, ip, sum;
        int unsigned       n;
        c   = pick_word();
        fb  = pick_word();
        ip  = pick_word();
        sum = c + fb + ip;
        case (kind)
            UNIT_GOOD: begin
                queue_frame(c, fb, ip, sum);
            end
            UNIT_BAD_SUM: begin
                if ($urandom_range(1))
                    queue_frame(c, fb, ip, sum ^ (32'h1 << $urandom_range(31)));
                else
                    queue_frame(c, fb, ip, sum + $urandom_range(1, 32'hFFFF));
            end
            UNIT_BROKEN_SYNC: begin
                n = $urandom_range(1, SYNC_RUN - 1);
                repeat (n) queue_byte(sync_now);
                queue_byte(sync_now ^ BYTE_W'($urandom_range(1, 255)));
            end
            default: begin
                // line noise, closed by a byte that cannot continue a sync run
                n = $urandom_range(1, 6);
                repeat (n) queue_byte(BYTE_W'($urandom_range(255)));
                queue_byte(sync_now ^ 8'h01);
            end
        endcase
    endtask

    // wait until every byte is in and every frame due has come out
    task automatic settle();
        int unsigned waited;
        waited = 0;
        while (bytes_taken != bytes_pushed)
            @(posedge i_clk);
        while (frames_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (frames_due.size() != 0) begin
            $error("%0d frames due never came out", frames_due.size());
            fail_count++;
            frames_due.delete();
        end
        // a dropped frame leaves no result but may still be in flight
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sync(input logic [BYTE_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sync_now = v;
    endtask

    // ------------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned start;
        int unsigned r;
        t_unit_kind  kind;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            // sender idles a little and receiver a lot, then the reverse, then neither
            case (ph / 2)
                0: begin send_idle_pct = 17; recv_idle_pct = 48; end
                1: begin send_idle_pct = 48; recv_idle_pct = 17; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase

            case (ph)
                0: ;                                  // reset value of the sync register
                1: write_sync(8'h00);
                3: write_sync(8'hFF);
                5: write_sync(8'h00);
                default: write_sync(BYTE_W'($urandom_range(255)));
            endcase

            if (ph == 0) begin
                // short sync run broken by a wrong byte, then a frame whose
                // command bytes equal the sync value and whose sum wraps
                queue_byte(sync_now);
                queue_byte(sync_now);
                queue_byte(8'h00);
                queue_frame(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h0000_0000);
            end

            // back the block up into its input while bytes keep coming
            if (ph == 4)
                hold_armed = 1'b1;

            start = bytes_pushed;
            while (bytes_pushed - start < PHASE_BYTES) begin
                r = $urandom_range(99);
                if (r < 70)
                    kind = UNIT_GOOD;
                else if (r < 80)
                    kind = UNIT_BAD_SUM;
                else if (r < 90)
                    kind = UNIT_BROKEN_SYNC;
                else
                    kind = UNIT_NOISE;
                queue_unit(kind);
            end

            settle();
        end

        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
